// ===== rtl/product_except_self_assert.svh =====
// assertion helpers for the product_except_self block
`ifndef PRODUCT_EXCEPT_SELF_ASSERT_SVH
`define PRODUCT_EXCEPT_SELF_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pes_pkg.sv =====
package pes_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned MAX_LEN_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } pes_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] product;
    logic                     truncated;
    logic                     last_result;
  } pes_out_t;

endpackage

// ===== rtl/product_except_self.sv =====
// Product of all other elements. Elements arrive one per transfer (start high while busy is
// low); a non-final element leaves busy low, so start may stay high to send the next.
// The transfer carrying last starts the backward pass, and busy stays high until the results
// of its n stored elements (at most MAX_LEN) are read out. Each stored element passes three
// steps (memory read, then two products on the single shared 32x32 multiplier), and the
// results are then read out in index order, one per cycle. Each result appears for exactly
// one cycle with result_valid_o high; the receiver cannot stall, so it must take every
// result as it comes. The final result of a vector appears in the cycle busy drops, and the
// next vector's first element may be sent in that same cycle. Products wrap to 32 bits;
// elements beyond MAX_LEN are dropped and every result of that vector carries truncated.
`include "product_except_self_assert.svh"

module product_except_self
  import pes_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  pes_in_t  in_i,
  output logic     result_valid_o,
  output pes_out_t result_o
);

  localparam int unsigned IW = $clog2(MAX_LEN);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_READ = 5'b00010,
    ST_MULP = 5'b00100,
    ST_MULS = 5'b01000,
    ST_EMIT = 5'b10000
  } pes_state_e;

  pes_state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic [IW-1:0]     last_idx_q, last_idx_d;
  logic [DATA_W-1:0] prefix_q, prefix_d;
  logic [DATA_W-1:0] suffix_q, suffix_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q, out_last_d;
  logic              out_trunc_q, out_trunc_d;

  logic [DATA_W-1:0] elem_mem [MAX_LEN];
  logic [DATA_W-1:0] pre_mem  [MAX_LEN];
  logic [DATA_W-1:0] elem_rd_q;
  logic [DATA_W-1:0] pre_rd_q;

  logic              elem_we;
  logic              pre_we;
  logic [IW-1:0]     pre_waddr;
  logic [DATA_W-1:0] pre_wdata;

  logic [DATA_W-1:0] mul_a, mul_b, mul_p;
  logic              accept;
  logic              has_room;

  assign busy     = (state_q != ST_LOAD);
  assign accept   = start && !busy;
  assign has_room = (cnt_q < CW'(MAX_LEN));

  // shared multiplier, low word only (wraps in two's complement)
  assign mul_p = DATA_W'(mul_a * mul_b);

  always_comb begin
    unique case (state_q)
      ST_LOAD: begin
        mul_a = prefix_q;
        mul_b = in_i.value;
      end
      ST_MULP: begin
        mul_a = pre_rd_q;
        mul_b = suffix_q;
      end
      ST_MULS: begin
        mul_a = suffix_q;
        mul_b = elem_rd_q;
      end
      default: begin
        mul_a = prefix_q;
        mul_b = suffix_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    last_idx_d  = last_idx_q;
    prefix_d    = prefix_q;
    suffix_d    = suffix_q;
    ovf_d       = ovf_q;
    out_valid_d = 1'b0;
    out_last_d  = out_last_q;
    out_trunc_d = out_trunc_q;
    elem_we     = 1'b0;
    pre_we      = 1'b0;
    pre_waddr   = cnt_q[IW-1:0];
    pre_wdata   = prefix_q;

    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (has_room) begin
            elem_we  = 1'b1;
            pre_we   = 1'b1;
            prefix_d = mul_p;
            cnt_d    = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            last_idx_d = has_room ? cnt_q[IW-1:0] : IW'(MAX_LEN - 1);
            idx_d      = has_room ? cnt_q[IW-1:0] : IW'(MAX_LEN - 1);
            suffix_d   = DATA_W'(1);
            state_d    = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_MULP;
      end
      ST_MULP: begin
        // result for this index overwrites its prefix entry
        pre_we    = 1'b1;
        pre_waddr = idx_q;
        pre_wdata = mul_p;
        state_d   = ST_MULS;
      end
      ST_MULS: begin
        suffix_d = mul_p;
        if (idx_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          idx_d   = idx_q - IW'(1);
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        // read issued now, result shows next cycle from the read register
        out_valid_d = 1'b1;
        out_last_d  = (idx_q == last_idx_q);
        out_trunc_d = ovf_q;
        if (idx_q == last_idx_q) begin
          state_d  = ST_LOAD;
          cnt_d    = '0;
          prefix_d = DATA_W'(1);
          ovf_d    = 1'b0;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      prefix_q    <= DATA_W'(1);
      suffix_q    <= DATA_W'(1);
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_trunc_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      last_idx_q  <= last_idx_d;
      prefix_q    <= prefix_d;
      suffix_q    <= suffix_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_trunc_q <= out_trunc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[cnt_q[IW-1:0]] <= in_i.value;
    end
    elem_rd_q <= elem_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (pre_we) begin
      pre_mem[pre_waddr] <= pre_wdata;
    end
    pre_rd_q <= pre_mem[idx_q];
  end

  assign result_valid_o       = out_valid_q;
  assign result_o.product     = pre_rd_q;
  assign result_o.truncated   = out_trunc_q;
  assign result_o.last_result = out_last_q;

  `PES_ASSERT_NXT(a_valid_from_emit, state_q != ST_EMIT, !out_valid_q,
                  "result strobe without a readout cycle")
  `PES_ASSERT_IMP(a_last_ends_vector, out_valid_q && out_last_q, state_q == ST_LOAD,
                  "final result while the sequencer is still busy")
  `PES_ASSERT_IMP(a_idx_in_range, state_q != ST_LOAD, idx_q <= last_idx_q,
                  "pass index beyond the final stored element")
  `PES_ASSERT_IMP(a_cnt_in_range, 1'b1, cnt_q <= CW'(MAX_LEN),
                  "element count beyond capacity")

endmodule
